// ----- sv/tbpc_pkg.sv -----
// Shared types and constants for the two-button press classifier.
package tbpc_pkg;

    // Register field widths
    localparam int PERIOD_W   = 10;
    localparam int DEBOUNCE_W = 10;
    localparam int LONG_W     = 14;
    localparam int WINDOW_W   = 14;

    // Configuration write channel
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTH_WINDOW   = 8'd3;

    // Register reset values
    localparam logic [PERIOD_W-1:0]   RST_SAMPLE_PERIOD = 10'd50;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE      = 10'd50;
    localparam logic [LONG_W-1:0]     RST_LONG_PRESS    = 14'd600;
    localparam logic [WINDOW_W-1:0]   RST_BOTH_WINDOW   = 14'd500;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SHORT_A = 3'd1,
        EV_SHORT_B = 3'd2,
        EV_LONG_A  = 3'd3,
        EV_LONG_B  = 3'd4,
        EV_BOTH    = 3'd5
    } press_event_t;

endpackage

// ----- sv/two_button_press_classifier_core.sv -----
// Two-button short/long press classifier, top level.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata[0] level_a, [1] level_b
//  m_*     | out | m_tvalid / m_tready  | m_tdata[2:0] press_event
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
//  One request per clock sustained while m_tready keeps the result draining; an
//  accepted input passes the input register, then classify logic into the result register.
//  The rate is set by the state update: time, hold and debounce registers
//  are read and written by the same classify stage.
//  rst_n clears all state but the payload registers asynchronously: time and
//  stamps to zero, buttons released and not held, registers to their defaults.
//  A stalled m_tready holds the result; the input register fills and then
//  s_tready drops. cfg_ready is always high.
module two_button_press_classifier_core
    import tbpc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [0] level_a, [1] level_b, [7:2] zero

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [2:0] press_event, [7:3] zero

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef logic [TIME_BITS-1:0] time_t;

    // Configuration registers
    logic [PERIOD_W-1:0]   period_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [LONG_W-1:0]     long_reg;
    logic [WINDOW_W-1:0]   window_reg;

    // Input register
    logic       in_valid_reg;
    logic [1:0] lvl_reg;

    // Result register
    logic         out_valid_reg;
    press_event_t event_reg;
    press_event_t event_next;

    // Classifier state, index 0 is button A, 1 is button B
    time_t      time_reg,  time_next;
    time_t      last_reg  [2];
    time_t      last_next [2];
    time_t      hold_reg  [2];
    time_t      hold_next [2];
    logic [1:0] held_reg,  held_next;
    logic [1:0] prev_reg,  prev_next;

    logic advance;
    logic fire;

    assign cfg_ready = 1'b1;

    // Result stage moves when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, event_reg};

    // Classify one sample against the state
    always_comb
    begin
        logic [1:0] chg;
        logic [1:0] short_rel;
        time_t      diff;
        time_t      mag;
        time_t      el0;
        time_t      el1;
        logic       long0;
        logic       long1;

        time_next  = time_reg + time_t'(period_reg);
        last_next  = last_reg;
        hold_next  = hold_reg;
        held_next  = held_reg;
        prev_next  = prev_reg;
        event_next = EV_NONE;

        for (int i = 0; i < 2; i++)
        begin
            // accepted level change: differs and debounce time has passed
            chg[i] = (lvl_reg[i] != prev_reg[i]) &&
                     ((time_next - last_reg[i]) > time_t'(debounce_reg));
            short_rel[i] = chg[i] && lvl_reg[i] &&
                           ((time_next - hold_reg[i]) < time_t'(long_reg));
        end

        if (chg[0])
        begin
            last_next[0] = time_next;
            if (!lvl_reg[0])
            begin
                hold_next[0] = time_next;
                held_next[0] = 1'b1;
            end
            else
            begin
                held_next[0] = 1'b0;
                prev_next[0] = 1'b1;
            end
        end

        // a short A ends the sample; button B is not looked at
        if (!short_rel[0] && chg[1])
        begin
            last_next[1] = time_next;
            if (!lvl_reg[1])
            begin
                hold_next[1] = time_next;
                held_next[1] = 1'b1;
            end
            else
            begin
                held_next[1] = 1'b0;
                prev_next[1] = 1'b1;
            end
        end

        // long-hold checks on the updated stamps
        diff  = hold_next[0] - hold_next[1];
        mag   = diff[TIME_BITS-1] ? (time_t'(0) - diff) : diff;
        el0   = time_next - hold_next[0];
        el1   = time_next - hold_next[1];
        long0 = el0 > time_t'(long_reg);
        long1 = el1 > time_t'(long_reg);

        if (short_rel[0])
        begin
            event_next = EV_SHORT_A;
        end
        else if (short_rel[1])
        begin
            event_next = EV_SHORT_B;
        end
        else if (held_next[0] && held_next[1] && (mag < time_t'(window_reg)) &&
                 long0 && long1)
        begin
            held_next  = 2'b00;
            event_next = EV_BOTH;
        end
        else if (held_next[0] && !held_next[1] && long0)
        begin
            held_next[0] = 1'b0;
            event_next   = EV_LONG_A;
        end
        else if (held_next[1] && !held_next[0] && long1)
        begin
            held_next[1] = 1'b0;
            event_next   = EV_LONG_B;
        end
        else
        begin
            prev_next = lvl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= RST_SAMPLE_PERIOD;
            debounce_reg  <= RST_DEBOUNCE;
            long_reg      <= RST_LONG_PRESS;
            window_reg    <= RST_BOTH_WINDOW;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
            hold_reg[0]   <= '0;
            hold_reg[1]   <= '0;
            held_reg      <= 2'b00;
            prev_reg      <= 2'b11;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SAMPLE_PERIOD: period_reg   <= cfg_data[PERIOD_W-1:0];
                    REG_DEBOUNCE:      debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                    REG_LONG_PRESS:    long_reg     <= cfg_data[LONG_W-1:0];
                    REG_BOTH_WINDOW:   window_reg   <= cfg_data[WINDOW_W-1:0];
                    default:           ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            if (fire)
            begin
                time_reg  <= time_next;
                last_reg  <= last_next;
                hold_reg  <= hold_next;
                held_reg  <= held_next;
                prev_reg  <= prev_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lvl_reg <= s_tdata[1:0];
        end
        if (fire)
        begin
            event_reg <= event_next;
        end
    end

    // Time moves by exactly one sample period per classified request
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> time_reg == $past(time_next))
        else $error("time did not advance by one sample period");

    // A short A, long A or both event always leaves button A not held
    a_a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (event_next == EV_SHORT_A || event_next == EV_LONG_A ||
                 event_next == EV_BOTH) |=> !held_reg[0])
        else $error("button A still held after its event");

    // Input side stalls only with both stages full and the output blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    // A classified sample shows up on the output on the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid && m_tdata[2:0] == $past(event_next))
        else $error("classified result not presented");

endmodule
